// ----- rtl/core/mrda_pkg.sv -----
// Shared types and constants of the mixed-radix duration accumulator.
package mrda_pkg;

    localparam int TOD_W = 27;
    localparam int ACC_W = 38;

    localparam logic [TOD_W-1:0] MS_PER_DAY    = 27'd86400000;
    localparam logic [TOD_W-1:0] MS_PER_HOUR   = 27'd3600000;
    localparam logic [TOD_W-1:0] MS_PER_MINUTE = 27'd60000;
    localparam logic [TOD_W-1:0] MS_PER_SECOND = 27'd1000;
    localparam int MONTHS_PER_YEAR = 12;

    typedef struct packed {
        logic        clear;
        logic [6:0]  add_years;
        logic [11:0] add_months;
        logic [15:0] add_days;
        logic [15:0] add_hours;
        logic [15:0] add_minutes;
        logic [15:0] add_seconds;
        logic [15:0] add_milliseconds;
    } in_t;

    typedef struct packed {
        logic [6:0] out_years;
        logic [3:0] out_months;
        logic [4:0] out_days;
        logic [4:0] out_hours;
        logic [5:0] out_minutes;
        logic [5:0] out_seconds;
        logic [9:0] out_millis;
    } out_t;

    // Fields that ride along the pipeline next to the dividers
    typedef struct packed {
        logic             clear;
        logic [6:0]       ay;
        logic [11:0]      amo;
        logic [15:0]      ad;
        logic [15:0]      ams;
        logic [TOD_W-1:0] rt;
        logic [4:0]       dr;
        logic [3:0]       mr;
        logic             nz;
        logic [6:0]       yv;
        logic [3:0]       mo;
        logic [4:0]       dd;
        logic [4:0]       hh;
        logic [5:0]       mm;
    } side_t;

endpackage

// ----- rtl/core/mrda_if.sv -----
// Valid/ready channel carrying one payload item per transfer.
interface mrda_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/mrda_cdiv.sv -----
// Three-stage divider by a constant: reciprocal multiply, back-multiply, one correction.
module mrda_cdiv #(
    parameter int WIDTH_X = 16,
    parameter int DIVISOR = 10,
    parameter int QW      = 8,
    parameter int RW      = 4
) (
    input  logic               clk,
    input  logic [2:0]         en,
    input  logic [WIDTH_X-1:0] x,
    output logic [QW-1:0]      q,
    output logic [RW-1:0]      r
);
    localparam longint unsigned MULT = (64'd1 << WIDTH_X) / DIVISOR;
    localparam int MW = $clog2(MULT + 1);
    localparam int PW = WIDTH_X + MW;
    localparam logic [MW-1:0]      MULT_V = MW'(MULT);
    localparam logic [WIDTH_X-1:0] DIV_V  = WIDTH_X'(DIVISOR);

    logic [PW-1:0]      prod;
    logic [WIDTH_X-1:0] x1_reg;
    logic [WIDTH_X-1:0] x2_reg;
    logic [WIDTH_X-1:0] p2_reg;
    logic [WIDTH_X-1:0] rem;
    logic [QW-1:0]      q1_reg;
    logic [QW-1:0]      q2_reg;
    logic [QW-1:0]      q3_reg;
    logic [RW-1:0]      r3_reg;

    // Estimate is exact or one short since x stays below 2**WIDTH_X
    assign prod = PW'(x) * PW'(MULT_V);
    assign rem  = x2_reg - p2_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x1_reg <= x;
            q1_reg <= QW'(prod >> WIDTH_X);
        end
        if (en[1])
        begin
            x2_reg <= x1_reg;
            q2_reg <= q1_reg;
            p2_reg <= WIDTH_X'(q1_reg) * DIV_V;
        end
        if (en[2])
        begin
            if (rem >= DIV_V)
            begin
                q3_reg <= q2_reg + QW'(1);
                r3_reg <= RW'(rem - DIV_V);
            end
            else
            begin
                q3_reg <= q2_reg;
                r3_reg <= RW'(rem);
            end
        end
    end

    assign q = q3_reg;
    assign r = r3_reg;
endmodule

// ----- rtl/core/mixed_radix_duration_accumulator.sv -----
// Top level: running years/months/days/time-of-day accumulator with normalized result.
//
//   channel | dir | payload        | handshake
//   --------+-----+----------------+-------------
//   din     | in  | mrda_pkg::in_t | valid/ready
//   dout    | out | mrda_pkg::out_t| valid/ready
//
// One item per cycle is accepted when the pipeline is not stalled. The only feedback
// loop is the state update stage, which adds pre-split remainders and ripples one
// carry per unit combinationally into the state registers.
// Reset clears the duration and all valid bits. Each stage holds while the stage after
// it is full and not advancing, so bubbles close up and a full output register does
// not stop input transfers until the whole pipeline is occupied.
module mixed_radix_duration_accumulator #(
    parameter int MAX_YEARS      = 67,
    parameter int DAYS_PER_MONTH = 30
) (
    input logic   clk,
    input logic   rst_n,
    mrda_if.sink   din,
    mrda_if.source dout
);
    localparam int NST      = 29;
    localparam int ST_DAY   = 3;
    localparam int ST_DSUM  = 6;
    localparam int ST_DPM   = 7;
    localparam int ST_MSUM  = 10;
    localparam int ST_MON   = 11;
    localparam int ST_YSUM  = 14;
    localparam int ST_YR    = 15;
    localparam int ST_LOOP  = 18;
    localparam int ST_HR    = 19;
    localparam int ST_MIN   = 22;
    localparam int ST_SEC   = 25;
    localparam int ST_OUT   = 28;

    localparam int TW = mrda_pkg::TOD_W;
    localparam int AW = mrda_pkg::ACC_W;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] adv;

    mrda_pkg::side_t side_reg  [ST_OUT];
    mrda_pkg::side_t side_next [ST_OUT];

    logic [15:0]   hrs_reg;
    logic [15:0]   mins_reg;
    logic [15:0]   secs_reg;
    logic [AW-1:0] ph_reg;
    logic [31:0]   pm_reg;
    logic [25:0]   ps_reg;
    logic [AW-1:0] a_reg;
    logic [16:0]   dsum_reg;
    logic [12:0]   msum_reg;
    logic [9:0]    z_reg;
    logic [9:0]    ysum;

    logic [11:0]   day_q;
    logic [TW-1:0] day_r;
    logic [11:0]   dpm_q;
    logic [4:0]    dpm_r;
    logic [9:0]    mon_q;
    logic [3:0]    mon_r;
    logic [6:0]    yr_r;
    logic [4:0]    hr_q;
    logic [21:0]   hr_r;
    logic [5:0]    min_q;
    logic [15:0]   min_r;
    logic [5:0]    sec_q;
    logic [9:0]    sec_r;

    // duration state
    logic [6:0]    year_reg;
    logic [3:0]    month_reg;
    logic [4:0]    day_reg;
    logic [TW-1:0] tod_reg;
    logic [6:0]    year_next;
    logic [3:0]    month_next;
    logic [4:0]    day_next;
    logic [TW-1:0] tod_next;
    logic          upd;

    logic          clr;
    logic [TW:0]   t_sum;
    logic          c_day;
    logic [5:0]    d_sum;
    logic          c_mon;
    logic [4:0]    mo_sum;
    logic          c_yr;
    logic [6:0]    yr_add;
    logic [7:0]    y_sum;

    mrda_pkg::out_t out_reg;

    // ---------------------------------------------------------------- flow control
    always_comb
    begin
        adv[NST-1] = !vld_reg[NST-1] || dout.ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = adv[0] ? din.valid : vld_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign din.ready  = adv[0];
    assign dout.valid = vld_reg[NST-1];
    assign dout.data  = out_reg;

    // ---------------------------------------------------------------- side fields
    always_comb
    begin
        side_next[0]       = '0;
        side_next[0].clear = din.data.clear;
        side_next[0].ay    = din.data.add_years;
        side_next[0].amo   = din.data.add_months;
        side_next[0].ad    = din.data.add_days;
        side_next[0].ams   = din.data.add_milliseconds;
        for (int k = 1; k < ST_OUT; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[ST_DSUM].rt = day_r;
        side_next[ST_MSUM].dr = dpm_r;
        side_next[ST_YSUM].mr = mon_r;
        side_next[ST_YSUM].nz = (ysum != '0);
        side_next[ST_HR].yv   = year_reg;
        side_next[ST_HR].mo   = month_reg;
        side_next[ST_HR].dd   = day_reg;
        side_next[ST_MIN].hh  = hr_q;
        side_next[ST_SEC].mm  = min_q;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ST_OUT; k++)
        begin
            if (adv[k])
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // ---------------------------------------------------------------- input side
    assign ysum = 10'(side_reg[ST_YSUM-1].ay) + mon_q;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            hrs_reg  <= din.data.add_hours;
            mins_reg <= din.data.add_minutes;
            secs_reg <= din.data.add_seconds;
        end
        if (adv[1])
        begin
            ph_reg <= AW'(hrs_reg) * AW'(mrda_pkg::MS_PER_HOUR);
            pm_reg <= 32'(mins_reg) * 32'(mrda_pkg::MS_PER_MINUTE);
            ps_reg <= 26'(secs_reg) * 26'(mrda_pkg::MS_PER_SECOND);
        end
        if (adv[2])
        begin
            a_reg <= ph_reg + AW'(pm_reg) + AW'(ps_reg) + AW'(side_reg[1].ams);
        end
        if (adv[ST_DSUM])
        begin
            dsum_reg <= 17'(side_reg[ST_DSUM-1].ad) + 17'(day_q);
        end
        if (adv[ST_MSUM])
        begin
            msum_reg <= 13'(side_reg[ST_MSUM-1].amo) + 13'(dpm_q);
        end
        // fold years as (total - 1) mod MAX + 1, keeping zero apart via nz
        if (adv[ST_YSUM])
        begin
            z_reg <= (ysum == '0) ? '0 : ysum - 10'd1;
        end
    end

    mrda_cdiv #(.WIDTH_X(AW), .DIVISOR(86400000), .QW(12), .RW(TW)) u_div_day (
        .clk (clk),
        .en  (adv[ST_DAY+2:ST_DAY]),
        .x   (a_reg),
        .q   (day_q),
        .r   (day_r)
    );

    mrda_cdiv #(.WIDTH_X(17), .DIVISOR(DAYS_PER_MONTH), .QW(12), .RW(5)) u_div_dpm (
        .clk (clk),
        .en  (adv[ST_DPM+2:ST_DPM]),
        .x   (dsum_reg),
        .q   (dpm_q),
        .r   (dpm_r)
    );

    mrda_cdiv #(.WIDTH_X(13), .DIVISOR(mrda_pkg::MONTHS_PER_YEAR), .QW(10), .RW(4)) u_div_mon (
        .clk (clk),
        .en  (adv[ST_MON+2:ST_MON]),
        .x   (msum_reg),
        .q   (mon_q),
        .r   (mon_r)
    );

    mrda_cdiv #(.WIDTH_X(10), .DIVISOR(MAX_YEARS), .QW(10), .RW(7)) u_div_yr (
        .clk (clk),
        .en  (adv[ST_YR+2:ST_YR]),
        .x   (z_reg),
        .q   (),
        .r   (yr_r)
    );

    // ---------------------------------------------------------------- state update
    assign upd = vld_reg[ST_LOOP-1] && adv[ST_LOOP];
    assign clr = side_reg[ST_LOOP-1].clear;

    always_comb
    begin
        t_sum      = (TW+1)'(clr ? '0 : tod_reg) + (TW+1)'(side_reg[ST_LOOP-1].rt);
        c_day      = (t_sum >= (TW+1)'(mrda_pkg::MS_PER_DAY));
        tod_next   = c_day ? TW'(t_sum - (TW+1)'(mrda_pkg::MS_PER_DAY)) : TW'(t_sum);

        d_sum      = 6'(clr ? '0 : day_reg) + 6'(side_reg[ST_LOOP-1].dr) + 6'(c_day);
        c_mon      = (d_sum >= 6'(DAYS_PER_MONTH));
        day_next   = c_mon ? 5'(d_sum - 6'(DAYS_PER_MONTH)) : 5'(d_sum);

        mo_sum     = 5'(clr ? '0 : month_reg) + 5'(side_reg[ST_LOOP-1].mr) + 5'(c_mon);
        c_yr       = (mo_sum >= 5'(mrda_pkg::MONTHS_PER_YEAR));
        month_next = c_yr ? 4'(mo_sum - 5'(mrda_pkg::MONTHS_PER_YEAR)) : 4'(mo_sum);

        yr_add     = side_reg[ST_LOOP-1].nz ? yr_r + 7'd1 : '0;
        y_sum      = 8'(clr ? '0 : year_reg) + 8'(yr_add) + 8'(c_yr);
        if (y_sum > 8'(2 * MAX_YEARS))
        begin
            year_next = 7'(y_sum - 8'(2 * MAX_YEARS));
        end
        else if (y_sum > 8'(MAX_YEARS))
        begin
            year_next = 7'(y_sum - 8'(MAX_YEARS));
        end
        else
        begin
            year_next = 7'(y_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= '0;
            month_reg <= '0;
            day_reg   <= '0;
            tod_reg   <= '0;
        end
        else if (upd)
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            tod_reg   <= tod_next;
        end
    end

    // ---------------------------------------------------------------- time split
    mrda_cdiv #(.WIDTH_X(TW), .DIVISOR(3600000), .QW(5), .RW(22)) u_div_hr (
        .clk (clk),
        .en  (adv[ST_HR+2:ST_HR]),
        .x   (tod_reg),
        .q   (hr_q),
        .r   (hr_r)
    );

    mrda_cdiv #(.WIDTH_X(22), .DIVISOR(60000), .QW(6), .RW(16)) u_div_min (
        .clk (clk),
        .en  (adv[ST_MIN+2:ST_MIN]),
        .x   (hr_r),
        .q   (min_q),
        .r   (min_r)
    );

    mrda_cdiv #(.WIDTH_X(16), .DIVISOR(1000), .QW(6), .RW(10)) u_div_sec (
        .clk (clk),
        .en  (adv[ST_SEC+2:ST_SEC]),
        .x   (min_r),
        .q   (sec_q),
        .r   (sec_r)
    );

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            out_reg.out_years   <= side_reg[ST_OUT-1].yv;
            out_reg.out_months  <= side_reg[ST_OUT-1].mo;
            out_reg.out_days    <= side_reg[ST_OUT-1].dd;
            out_reg.out_hours   <= side_reg[ST_OUT-1].hh;
            out_reg.out_minutes <= side_reg[ST_OUT-1].mm;
            out_reg.out_seconds <= sec_q;
            out_reg.out_millis  <= sec_r;
        end
    end

    // ---------------------------------------------------------------- checks
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> (year_reg <= 7'(MAX_YEARS)) && (month_reg < 4'(mrda_pkg::MONTHS_PER_YEAR))
                && (day_reg < 5'(DAYS_PER_MONTH)) && (tod_reg < mrda_pkg::MS_PER_DAY))
        else $error("duration state out of range after update");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !upd |=> $stable(year_reg) && $stable(month_reg) && $stable(day_reg)
                 && $stable(tod_reg))
        else $error("duration state changed without an item");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !dout.valid |-> din.ready)
        else $error("input stalled while output register is empty");
endmodule
